>>> design/aabb_frustum_cull_test_assert.svh
// Assertion macros used by the frustum cull plane cell.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef AABB_FRUSTUM_CULL_TEST_ASSERT_SVH
`define AABB_FRUSTUM_CULL_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFC_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("frustum cull assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AFC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("frustum cull assertion failed");

`endif

>>> design/afc_pkg.sv
// Shared types and constants for the axis-aligned box frustum cull test.
// No dependencies; used by afc_plane_cell and aabb_frustum_cull_test.
`default_nettype none

package afc_pkg;

    // Plane register packing: a, b, c signed coefficients, then d in map units.
    localparam int COEF_BITS   = 14;
    localparam int D_BITS      = 22;
    localparam int PLANE_W     = 64;
    localparam int PLANE_COUNT = 6;
    localparam int REG_IDX_W   = 3;

    localparam int DEF_COORD_BITS     = 20;
    localparam int DEF_COEF_FRAC_BITS = 12;

    // Positions of the corner coordinates in the box bundle passed down the chain.
    localparam int BOX_FIELDS = 6;
    localparam int BOX_MIN_X  = 0;
    localparam int BOX_MIN_Y  = 1;
    localparam int BOX_MIN_Z  = 2;
    localparam int BOX_MAX_X  = 3;
    localparam int BOX_MAX_Y  = 4;
    localparam int BOX_MAX_Z  = 5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PLANE_LEFT   = 3'd0,
        REG_PLANE_RIGHT  = 3'd1,
        REG_PLANE_TOP    = 3'd2,
        REG_PLANE_BOTTOM = 3'd3,
        REG_PLANE_NEAR   = 3'd4,
        REG_PLANE_FAR    = 3'd5
    } afc_reg_t;

    // Control handed from one plane cell to the next.
    typedef struct packed {
        logic valid;
        logic visible;
    } afc_ctl_t;

endpackage

`default_nettype wire

>>> design/aabb_frustum_cull_test.sv
// A box accepted with start gives its in_view result with done high after it has
// passed the two register stages in each of the six plane cells.
// Throughput: one box per cycle; busy is always low and the result cannot stall.
// Reset clears all six plane registers to zero (every box out of view) and
// empties the pipeline, so no done strobe appears for boxes in flight.
// Depends on afc_pkg and afc_plane_cell.
`default_nettype none

module aabb_frustum_cull_test #(
    parameter int COORD_BITS     = afc_pkg::DEF_COORD_BITS,
    parameter int COEF_FRAC_BITS = afc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_BITS-1:0]    box_min_x,
    input  logic signed [COORD_BITS-1:0]    box_min_y,
    input  logic signed [COORD_BITS-1:0]    box_min_z,
    input  logic signed [COORD_BITS-1:0]    box_max_x,
    input  logic signed [COORD_BITS-1:0]    box_max_y,
    input  logic signed [COORD_BITS-1:0]    box_max_z,
    output logic                            done,
    output logic                            in_view,
    input  logic                            cfg_we,
    input  logic [afc_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]     cfg_data
);
    import afc_pkg::*;

    logic [PLANE_COUNT-1:0] plane_we;

    afc_ctl_t ctl_chain [PLANE_COUNT+1];
    logic [BOX_FIELDS-1:0][COORD_BITS-1:0] box_chain [PLANE_COUNT];

    always_comb
    begin
        plane_we = '0;
        unique case (cfg_index)
            REG_PLANE_LEFT:   plane_we[0] = cfg_we;
            REG_PLANE_RIGHT:  plane_we[1] = cfg_we;
            REG_PLANE_TOP:    plane_we[2] = cfg_we;
            REG_PLANE_BOTTOM: plane_we[3] = cfg_we;
            REG_PLANE_NEAR:   plane_we[4] = cfg_we;
            REG_PLANE_FAR:    plane_we[5] = cfg_we;
            default:          plane_we = '0;
        endcase
    end

    assign busy = 1'b0;

    assign ctl_chain[0].valid   = start && !busy;
    assign ctl_chain[0].visible = 1'b1;
    assign box_chain[0][BOX_MIN_X] = box_min_x;
    assign box_chain[0][BOX_MIN_Y] = box_min_y;
    assign box_chain[0][BOX_MIN_Z] = box_min_z;
    assign box_chain[0][BOX_MAX_X] = box_max_x;
    assign box_chain[0][BOX_MAX_Y] = box_max_y;
    assign box_chain[0][BOX_MAX_Z] = box_max_z;

    for (genvar k = 0; k < PLANE_COUNT; k++)
    begin : g_cell
        if (k < PLANE_COUNT - 1)
        begin : g_mid
            afc_plane_cell #(
                .COORD_BITS     (COORD_BITS),
                .COEF_FRAC_BITS (COEF_FRAC_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .plane_we   (plane_we[k]),
                .plane_data (cfg_data),
                .ctl_in     (ctl_chain[k]),
                .box_in     (box_chain[k]),
                .ctl_out    (ctl_chain[k+1]),
                .box_out    (box_chain[k+1])
            );
        end
        else
        begin : g_last
            // The last cell has no neighbor to hand the box to.
            afc_plane_cell #(
                .COORD_BITS     (COORD_BITS),
                .COEF_FRAC_BITS (COEF_FRAC_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .plane_we   (plane_we[k]),
                .plane_data (cfg_data),
                .ctl_in     (ctl_chain[k]),
                .box_in     (box_chain[k]),
                .ctl_out    (ctl_chain[k+1]),
                .box_out    ()
            );
        end
    end

    assign done    = ctl_chain[PLANE_COUNT].valid;
    assign in_view = ctl_chain[PLANE_COUNT].visible;

endmodule

`default_nettype wire

>>> design/afc_plane_cell.sv
// One plane cell of the frustum cull chain: holds one plane register and tests
// the passing box against it in two register stages. Depends on afc_pkg.
`default_nettype none
`include "aabb_frustum_cull_test_assert.svh"

module afc_plane_cell #(
    parameter int COORD_BITS     = afc_pkg::DEF_COORD_BITS,
    parameter int COEF_FRAC_BITS = afc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           plane_we,
    input  logic [afc_pkg::PLANE_W-1:0]                    plane_data,
    input  afc_pkg::afc_ctl_t                              ctl_in,
    input  logic [afc_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0] box_in,
    output afc_pkg::afc_ctl_t                              ctl_out,
    output logic [afc_pkg::BOX_FIELDS-1:0][COORD_BITS-1:0] box_out
);
    import afc_pkg::*;

    localparam int PROD_W  = COEF_BITS + COORD_BITS;
    localparam int DSCL_W  = D_BITS + COEF_FRAC_BITS;
    localparam int SUM_W   = ((PROD_W > DSCL_W) ? PROD_W : DSCL_W) + 2;

    logic [PLANE_W-1:0] plane_reg;

    afc_ctl_t ctl_s1_reg;
    afc_ctl_t ctl_s1_next;
    afc_ctl_t ctl_s2_reg;
    afc_ctl_t ctl_s2_next;

    logic [BOX_FIELDS-1:0][COORD_BITS-1:0] box_s1_reg;
    logic [BOX_FIELDS-1:0][COORD_BITS-1:0] box_s2_reg;

    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];

    logic signed [COEF_BITS-1:0]  coef [3];
    logic signed [COORD_BITS-1:0] lo   [3];
    logic signed [COORD_BITS-1:0] hi   [3];
    logic signed [COORD_BITS-1:0] pick [3];

    logic signed [D_BITS-1:0] d_coef;
    logic signed [SUM_W-1:0]  d_scaled;
    logic signed [SUM_W-1:0]  sum_s2;
    logic                     above;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg  <= '0;
            ctl_s1_reg <= '0;
            ctl_s2_reg <= '0;
        end
        else
        begin
            if (plane_we)
            begin
                plane_reg <= plane_data;
            end
            ctl_s1_reg <= ctl_s1_next;
            ctl_s2_reg <= ctl_s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_s1_reg <= box_in;
        box_s2_reg <= box_s1_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
    end

    // Stage 1: per axis, the corner coordinate that maximizes the term is the
    // larger one for a non-negative coefficient and the smaller one otherwise.
    always_comb
    begin
        coef[0] = plane_reg[COEF_BITS-1:0];
        coef[1] = plane_reg[2*COEF_BITS-1:COEF_BITS];
        coef[2] = plane_reg[3*COEF_BITS-1:2*COEF_BITS];
        lo[0]   = box_in[BOX_MIN_X];
        lo[1]   = box_in[BOX_MIN_Y];
        lo[2]   = box_in[BOX_MIN_Z];
        hi[0]   = box_in[BOX_MAX_X];
        hi[1]   = box_in[BOX_MAX_Y];
        hi[2]   = box_in[BOX_MAX_Z];
        for (int i = 0; i < 3; i++)
        begin
            if (coef[i][COEF_BITS-1])
            begin
                pick[i] = (lo[i] < hi[i]) ? lo[i] : hi[i];
            end
            else
            begin
                pick[i] = (lo[i] < hi[i]) ? hi[i] : lo[i];
            end
            prod_next[i] = PROD_W'(coef[i]) * PROD_W'(pick[i]);
        end
        ctl_s1_next = ctl_in;
    end

    // Stage 2: the largest plane value over all corners, compared against zero.
    always_comb
    begin
        d_coef   = plane_reg[PLANE_W-1:3*COEF_BITS];
        d_scaled = SUM_W'(d_coef) <<< COEF_FRAC_BITS;
        sum_s2   = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                 + d_scaled;
        above    = !sum_s2[SUM_W-1] && (sum_s2 != '0);
        ctl_s2_next.valid   = ctl_s1_reg.valid;
        ctl_s2_next.visible = ctl_s1_reg.visible & above;
    end

    assign ctl_out = ctl_s2_reg;
    assign box_out = box_s2_reg;

    `AFC_ASSERT_NEXT(a_valid_into_s1, ctl_in.valid, ctl_s1_reg.valid)
    `AFC_ASSERT_NEXT(a_bubble_into_s1, !ctl_in.valid, !ctl_s1_reg.valid)
    `AFC_ASSERT_NEXT(a_valid_into_s2, ctl_s1_reg.valid, ctl_s2_reg.valid)
    `AFC_ASSERT_NEXT(a_reject_sticks, ctl_s1_reg.valid && !ctl_s1_reg.visible,
                     !ctl_s2_reg.visible)

endmodule

`default_nettype wire

>>> sim/aabb_frustum_cull_test_tb.sv
// Self-checking testbench for the six-plane box frustum cull block.
// Predicts in_view from a shadow copy of the plane registers; needs afc_pkg and the RTL.
// Directed boxes and extreme planes, then random streams under several sender idle mixes.
module aabb_frustum_cull_test_tb;
    import afc_pkg::*;

    localparam int CW          = DEF_COORD_BITS;
    localparam int FRAC        = DEF_COEF_FRAC_BITS;
    localparam int LATENCY     = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;
    localparam int COORD_MIN   = -(1 << (CW - 1));
    localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
    localparam int COEF_MIN    = -(1 << (COEF_BITS - 1));
    localparam int COEF_MAX    = (1 << (COEF_BITS - 1)) - 1;
    localparam int D_MIN       = -(1 << (D_BITS - 1));
    localparam int D_MAX       = (1 << (D_BITS - 1)) - 1;
    localparam int COEF_ONE    = 1 << FRAC;
    localparam int RANDOM_PER_CONFIG = 105;

    // Indexes past the last plane; writes there must not land anywhere.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [CW-1:0]   box_min_x;
    logic signed [CW-1:0]   box_min_y;
    logic signed [CW-1:0]   box_min_z;
    logic signed [CW-1:0]   box_max_x;
    logic signed [CW-1:0]   box_max_y;
    logic signed [CW-1:0]   box_max_z;
    logic                   done;
    logic                   in_view;
    logic                   cfg_we;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic [PLANE_W-1:0]     cfg_data;

    logic [PLANE_W-1:0]     plane_shadow [PLANE_COUNT];
    logic                   in_view_expected [$];
    logic                   oldest_view;
    int                     boxes_accepted;
    int                     views_checked;
    int                     mismatch_count;
    int                     plane_writes;
    int                     cycle_count;
    int                     sender_idle_pct;
    int                     box_span;
    int                     box_half;

    aabb_frustum_cull_test #(
        .COORD_BITS     (CW),
        .COEF_FRAC_BITS (FRAC)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_min_z (box_min_z),
        .box_max_x (box_max_x),
        .box_max_y (box_max_y),
        .box_max_z (box_max_z),
        .done      (done),
        .in_view   (in_view),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // A box is visible unless some plane keeps all eight corners at or below zero.
    function automatic logic predict_in_view(input longint lx, input longint ly,
                                             input longint lz, input longint hx,
                                             input longint hy, input longint hz);
        logic [PLANE_W-1:0] p;
        longint a, b, c, d_scaled, x, y, z;
        logic any_corner_above;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            p = plane_shadow[i];
            a = longint'($signed(p[COEF_BITS-1:0]));
            b = longint'($signed(p[2*COEF_BITS-1:COEF_BITS]));
            c = longint'($signed(p[3*COEF_BITS-1:2*COEF_BITS]));
            d_scaled = longint'($signed(p[PLANE_W-1:3*COEF_BITS])) * (longint'(1) << FRAC);
            any_corner_above = 1'b0;
            for (int k = 0; k < 8; k++) begin
                x = k[0] ? hx : lx;
                y = k[1] ? hy : ly;
                z = k[2] ? hz : lz;
                if (a * x + b * y + c * z + d_scaled > 0)
                    any_corner_above = 1'b1;
            end
            if (!any_corner_above)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(input int a, input int b, input int c,
                                                      input int d);
        logic [COEF_BITS-1:0] a_bits, b_bits, c_bits;
        logic [D_BITS-1:0]    d_bits;
        a_bits = a[COEF_BITS-1:0];
        b_bits = b[COEF_BITS-1:0];
        c_bits = c[COEF_BITS-1:0];
        d_bits = d[D_BITS-1:0];
        return {d_bits, c_bits, b_bits, a_bits};
    endfunction

    // Results are checked against the oldest prediction; accepted boxes and
    // register writes update the prediction side at the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done !== 1'b0) begin
                if (in_view_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result transaction, in_view %b",
                                 $time, in_view);
                end else begin
                    oldest_view = in_view_expected.pop_front();
                    views_checked++;
                    if (done !== 1'b1 || in_view !== oldest_view) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: in_view mismatch, expected %b, actual %b (done %b)",
                                     $time, oldest_view, in_view, done);
                    end
                end
            end
            if (start && !busy) begin
                in_view_expected.push_back(predict_in_view(box_min_x, box_min_y, box_min_z,
                                                           box_max_x, box_max_y, box_max_z));
                boxes_accepted++;
            end
            if (cfg_we && cfg_index < PLANE_COUNT)
                plane_shadow[cfg_index] = cfg_data;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     in_view_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_box(input int lx, input int ly, input int lz,
                            input int hx, input int hy, input int hz);
        @(negedge clk);
        start     <= 1'b1;
        box_min_x <= lx[CW-1:0];
        box_min_y <= ly[CW-1:0];
        box_min_z <= lz[CW-1:0];
        box_max_x <= hx[CW-1:0];
        box_max_y <= hy[CW-1:0];
        box_max_z <= hz[CW-1:0];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result transaction.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (in_view_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_plane(input logic [REG_IDX_W-1:0] idx, input logic [PLANE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        plane_writes++;
    endtask

    // Axis-aligned cube of half-width half_w around the origin.
    task automatic set_cube(input int half_w);
        drain();
        write_plane(REG_PLANE_LEFT,   pack_plane( COEF_ONE, 0, 0, half_w));
        write_plane(REG_PLANE_RIGHT,  pack_plane(-COEF_ONE, 0, 0, half_w));
        write_plane(REG_PLANE_TOP,    pack_plane(0, -COEF_ONE, 0, half_w));
        write_plane(REG_PLANE_BOTTOM, pack_plane(0,  COEF_ONE, 0, half_w));
        write_plane(REG_PLANE_NEAR,   pack_plane(0, 0,  COEF_ONE, half_w));
        write_plane(REG_PLANE_FAR,    pack_plane(0, 0, -COEF_ONE, half_w));
    endtask

    task automatic set_all_planes(input logic [PLANE_W-1:0] value);
        drain();
        for (int i = 0; i < PLANE_COUNT; i++)
            write_plane(afc_reg_t'(i), value);
    endtask

    task automatic send_random_box();
        int cx, cy, cz, lx, ly, lz, hx, hy, hz, t;
        if ($urandom_range(0, 9) < 2) begin
            send_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end else begin
            cx = int'($urandom_range(0, 2 * box_span)) - box_span;
            cy = int'($urandom_range(0, 2 * box_span)) - box_span;
            cz = int'($urandom_range(0, 2 * box_span)) - box_span;
            lx = cx - int'($urandom_range(0, box_half));
            ly = cy - int'($urandom_range(0, box_half));
            lz = cz - int'($urandom_range(0, box_half));
            hx = cx + int'($urandom_range(0, box_half));
            hy = cy + int'($urandom_range(0, box_half));
            hz = cz + int'($urandom_range(0, box_half));
            if ($urandom_range(0, 9) == 0) begin
                t = lx; lx = hx; hx = t;
                t = lz; lz = hz; hz = t;
            end
            send_box(lx, ly, lz, hx, hy, hz);
        end
    endtask

    task automatic test_reset_state();
        send_box(0, 0, 0, 0, 0, 0);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    endtask

    task automatic test_cube_cases();
        set_cube(1000);
        send_box(-10, -10, -10, 10, 10, 10);
        send_box(-3000, -10, -10, -2000, 10, 10);
        send_box(2000, -10, -10, 3000, 10, 10);
        send_box(-10, 2000, -10, 10, 3000, 10);
        send_box(-10, -3000, -10, 10, -2000, 10);
        send_box(-10, -10, -3000, 10, 10, -2000);
        send_box(-10, -10, 2000, 10, 10, 3000);
        send_box(-1500, -10, -10, -500, 10, 10);
        // Touching the left plane from outside sums to exactly zero.
        send_box(-2000, -10, -10, -1000, 10, 10);
        send_box(-2000, -10, -10, -999, 10, 10);
        // Swapped corners must give the same answer as ordered ones.
        send_box(10, 10, 10, -10, -10, -10);
        send_box(-2000, 10, 10, -3000, -10, -10);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_box(0, 0, 0, 0, 0, 0);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    endtask

    task automatic test_unused_index();
        drain();
        // A zero plane would reject everything if either write landed on a real plane.
        write_plane(REG_UNUSED_LO, '0);
        write_plane(REG_UNUSED_HI, '0);
        send_box(-10, -10, -10, 10, 10, 10);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    endtask

    task automatic test_extreme_planes();
        set_all_planes(pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, D_MAX));
        send_box(0, 0, 0, 0, 0, 0);
        send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        set_all_planes(pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, D_MIN));
        send_box(0, 0, 0, 0, 0, 0);
        send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // Zero normal with positive offset passes every box.
        set_all_planes(pack_plane(0, 0, 0, 1));
        send_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    endtask

    task automatic test_random_stream(input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int setting = 0; setting < 3; setting++) begin
            drain();
            if (setting == 0) begin
                set_cube($urandom_range(1000, 400000));
                box_span = 300000;
                box_half = 100000;
            end else if (setting == 1) begin
                // Random normals with a non-negative offset keep the origin inside when the offset is nonzero.
                for (int i = 0; i < PLANE_COUNT; i++)
                    write_plane(afc_reg_t'(i),
                                pack_plane(int'($urandom_range(0, 16383)) + COEF_MIN,
                                           int'($urandom_range(0, 16383)) + COEF_MIN,
                                           int'($urandom_range(0, 16383)) + COEF_MIN,
                                           $urandom_range(0, 200000)));
                box_span = 200000;
                box_half = 50000;
            end else begin
                for (int i = 0; i < PLANE_COUNT; i++)
                    write_plane(afc_reg_t'(i), $urandom_range(0, 1) ?
                                {$urandom(), $urandom()} : pack_plane(0, 0, 0, 1));
                box_span = 400000;
                box_half = 100000;
            end
            for (int n = 0; n < RANDOM_PER_CONFIG; n++)
                send_random_box();
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        box_min_x = '0;
        box_min_y = '0;
        box_min_z = '0;
        box_max_x = '0;
        box_max_y = '0;
        box_max_z = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idle_pct = 0;
        box_span = 1000;
        box_half = 100;
        for (int i = 0; i < PLANE_COUNT; i++)
            plane_shadow[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_cube_cases();
        test_unused_index();
        test_extreme_planes();
        test_random_stream(0);
        test_random_stream(62);
        test_random_stream(37);

        drain();
        repeat (LATENCY + 4) @(posedge clk);
        $display("Checked %0d of %0d boxes against %0d plane register writes,", views_checked,
                 boxes_accepted, plane_writes);
        $display("with sender idle mixes of 0, 62 and 37 percent; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && in_view_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> aabb_frustum_cull_test.f
+incdir+design
design/afc_pkg.sv
design/afc_plane_cell.sv
design/aabb_frustum_cull_test.sv
sim/aabb_frustum_cull_test_tb.sv
